// ===== sv/mmic_pkg.sv =====
// Package with the Michael MIC types, constants and block function.
package mmic_pkg;

  localparam logic [7:0]  PAD_BYTE = 8'h5A;
  localparam logic [31:0] MASK_HI  = 32'hff00ff00;
  localparam logic [31:0] MASK_LO  = 32'h00ff00ff;
  localparam int          ROT_A    = 17;
  localparam int          ROT_B    = 3;
  localparam int          ROT_C    = 30;  // rotate right by 2
  localparam logic [1:0]  LAST_LANE = 2'd3;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] l;
  } mic_halves_t;

  typedef struct packed {
    mic_halves_t halves;
    logic [31:0] word;
  } mic_item_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] swap_halfword_bytes(input logic [31:0] v);
    return ((v & MASK_HI) >> 8) | ((v & MASK_LO) << 8);
  endfunction

  // One pass of the Michael block function over a 32-bit word.
  function automatic mic_halves_t michael_block(input mic_halves_t h, input logic [31:0] w);
    logic [31:0] l;
    logic [31:0] r;
    mic_halves_t res;
    l = h.l ^ w;
    r = h.r ^ rotl32(l, ROT_A);
    l = l + r;
    r = r ^ swap_halfword_bytes(l);
    l = l + r;
    r = r ^ rotl32(l, ROT_B);
    l = l + r;
    r = r ^ rotl32(l, ROT_C);
    l = l + r;
    res.l = l;
    res.r = r;
    return res;
  endfunction

endpackage

// ===== sv/mmic_if.sv =====
// Stream interfaces for message bytes in and MIC values out.
interface mmic_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_item;

  modport source(output valid, output data_byte, output has_byte, output last_item,
                 input ready);
  modport sink(input valid, input data_byte, input has_byte, input last_item,
               output ready);
endinterface

interface mmic_mic_if;
  logic        valid;
  logic        ready;
  logic [63:0] mic_value;

  modport source(output valid, output mic_value, input ready);
  modport sink(input valid, input mic_value, output ready);
endinterface

// ===== sv/mmic_round_stage.sv =====
// Pipeline stage that runs one Michael block and registers the halves.
module mmic_round_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  mmic_pkg::mic_item_t    up_item,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output mmic_pkg::mic_halves_t  dn_halves
);

  logic                  valid;
  mmic_pkg::mic_halves_t halves;

  assign up_ready  = !valid || dn_ready;
  assign dn_valid  = valid;
  assign dn_halves = halves;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      halves <= mmic_pkg::michael_block(up_item.halves, up_item.word);
    end
  end

endmodule

// ===== sv/michael_mic_stream.sv =====
// Top level of the streaming Michael MIC (TKIP) generator.
//
// The msg channel carries one transaction per message byte: data_byte with
// has_byte set, or a transaction without a byte. A transaction with last_item
// set closes the message; the MIC for it leaves on the mic channel as one
// 64-bit transaction, left half in bits 31..0 and right half in bits 63..32.
// The first transaction of a message loads both halves from the key register
// written through cfg_wr_en / cfg_wr_data; a key written while a message is
// open takes effect with the next message.
// Throughput is one msg transaction per cycle while msg ready is high. The
// byte path packs bytes and runs at most one Michael block per cycle; the
// closing padding needs two more blocks, which run in two pipeline stages
// behind it, one block each, after the first closing stage registers the
// closing transaction. When the mic receiver stalls, the closing stages hold
// their contents and fill up; msg ready drops only when the first closing
// stage is full and cannot move forward, so up to three MICs can be in flight.
// Synchronous reset clears the key, the halves, the byte packer and all
// pipeline valid bits; the next transaction after reset opens a new message.
module michael_mic_stream (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [63:0]  cfg_wr_data,
  mmic_msg_if.sink     msg,
  mmic_mic_if.source   mic
);

  // Key register and the running message state.
  logic [63:0] mic_key;
  logic [31:0] left_half;
  logic [31:0] right_half;
  logic [23:0] partial_word;
  logic [1:0]  bytes_held;
  logic        message_open;

  // First closing stage: halves after the data byte, plus the padding word.
  logic                s1_valid;
  mmic_pkg::mic_item_t s1_item;
  logic                s1_ready;

  // Second closing stage output, which feeds the final all-zero block.
  logic                  s2_valid;
  logic                  s2_ready;
  mmic_pkg::mic_halves_t s2_halves;
  mmic_pkg::mic_item_t   s2_item;

  mmic_pkg::mic_halves_t mic_halves;

  logic                  accept;
  mmic_pkg::mic_halves_t cur_halves;
  mmic_pkg::mic_halves_t blk_halves;
  mmic_pkg::mic_halves_t halves_next;
  logic [23:0]           cur_word;
  logic [1:0]            cur_held;
  logic [31:0]           full_word;
  logic                  run_block;
  logic [23:0]           partial_word_next;
  logic [1:0]            bytes_held_next;
  logic [31:0]           pad_word;

  assign accept    = msg.valid && msg.ready;
  assign msg.ready = !s1_valid || s1_ready;

  always_comb begin
    // A closed message starts from the key with an empty packer.
    if (message_open) begin
      cur_halves.l = left_half;
      cur_halves.r = right_half;
      cur_word     = partial_word;
      cur_held     = bytes_held;
    end else begin
      cur_halves.l = mic_key[31:0];
      cur_halves.r = mic_key[63:32];
      cur_word     = '0;
      cur_held     = '0;
    end

    full_word  = {msg.data_byte, cur_word};
    run_block  = msg.has_byte && (cur_held == mmic_pkg::LAST_LANE);
    blk_halves = mmic_pkg::michael_block(cur_halves, full_word);
    halves_next = run_block ? blk_halves : cur_halves;

    // Pack the byte little-endian into the unfinished word.
    partial_word_next = cur_word;
    bytes_held_next   = cur_held;
    if (msg.has_byte) begin
      bytes_held_next = cur_held + 2'd1;
      case (cur_held)
        2'd0:    partial_word_next = {cur_word[23:8], msg.data_byte};
        2'd1:    partial_word_next = {cur_word[23:16], msg.data_byte, cur_word[7:0]};
        2'd2:    partial_word_next = {msg.data_byte, cur_word[15:0]};
        default: partial_word_next = '0;
      endcase
    end

    // The padding byte lands right after the held bytes; the four zero bytes
    // and the fill to a word boundary always make exactly one all-zero word.
    case (bytes_held_next)
      2'd0:    pad_word = {24'h0, mmic_pkg::PAD_BYTE};
      2'd1:    pad_word = {16'h0, mmic_pkg::PAD_BYTE, partial_word_next[7:0]};
      2'd2:    pad_word = {8'h0, mmic_pkg::PAD_BYTE, partial_word_next[15:0]};
      default: pad_word = {mmic_pkg::PAD_BYTE, partial_word_next};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mic_key      <= '0;
      left_half    <= '0;
      right_half   <= '0;
      partial_word <= '0;
      bytes_held   <= '0;
      message_open <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mic_key <= cfg_wr_data;
      end
      if (accept) begin
        left_half    <= halves_next.l;
        right_half   <= halves_next.r;
        partial_word <= partial_word_next;
        bytes_held   <= bytes_held_next;
        message_open <= !msg.last_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= accept && msg.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg.last_item) begin
      s1_item.halves <= halves_next;
      s1_item.word   <= pad_word;
    end
  end

  // Block over the padding word.
  mmic_round_stage u_pad_stage (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .up_item   (s1_item),
    .dn_valid  (s2_valid),
    .dn_ready  (s2_ready),
    .dn_halves (s2_halves)
  );

  assign s2_item.halves = s2_halves;
  assign s2_item.word   = '0;

  // Block over the all-zero word; its register is the output register.
  mmic_round_stage u_zero_stage (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s2_valid),
    .up_ready  (s2_ready),
    .up_item   (s2_item),
    .dn_valid  (mic.valid),
    .dn_ready  (mic.ready),
    .dn_halves (mic_halves)
  );

  assign mic.mic_value = {mic_halves.r, mic_halves.l};

`ifndef SYNTHESIS
  // A closing transaction always lands in the first closing stage.
  assert property (@(posedge clk) disable iff (rst)
    accept && msg.last_item |=> s1_valid)
    else $error("closing transaction did not reach the padding stage");

  // The message stays open exactly until its closing transaction.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (message_open == !$past(msg.last_item)))
    else $error("message open flag out of step with last_item");

  // A byte in the middle of a word advances the packer by one.
  assert property (@(posedge clk) disable iff (rst)
    accept && message_open && msg.has_byte && !msg.last_item && bytes_held == 2'd1
    |=> bytes_held == 2'd2)
    else $error("byte packer count did not advance");
`endif

endmodule

// ===== test/mic_check.sv =====
`timescale 1ns / 100ps
// Checker for the Michael MIC stream: tracks the key, predicts every MIC and compares.
module mic_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  mmic_msg_if         msg,
  mmic_mic_if         mic,
  output int          fail_count,
  output int          pending
);

  localparam logic [7:0] TRAILER_BYTE = 8'h5A;
  localparam int         ZERO_TAIL    = 4;
  localparam int         SPIN_FIRST   = 17;
  localparam int         SPIN_SECOND  = 3;
  localparam int         SPIN_THIRD   = 30;

  logic [63:0] key_copy;
  logic [31:0] left_h;
  logic [31:0] right_h;
  logic [31:0] word_acc;
  logic [1:0]  lane;
  logic        msg_open;
  logic [63:0] mic_due[$];

  function automatic logic [31:0] spin(input logic [31:0] v, input int n);
    logic [63:0] twice;
    twice = {v, v};
    return twice[63 - n -: 32];
  endfunction

  task automatic mix_word(input logic [31:0] w);
    logic [31:0] l;
    logic [31:0] r;
    l = left_h ^ w;
    r = right_h ^ spin(l, SPIN_FIRST);
    l = l + r;
    r = r ^ {l[23:16], l[31:24], l[7:0], l[15:8]};
    l = l + r;
    r = r ^ spin(l, SPIN_SECOND);
    l = l + r;
    r = r ^ spin(l, SPIN_THIRD);
    l = l + r;
    left_h  = l;
    right_h = r;
  endtask

  // Bytes fill the word from the low lane up; the fourth byte runs the mix.
  task automatic take_byte(input logic [7:0] b);
    logic [31:0] w;
    w = word_acc | ({24'd0, b} << (8 * lane));
    if (lane == 2'd3) begin
      mix_word(w);
      word_acc = '0;
      lane     = '0;
    end else begin
      word_acc = w;
      lane     = lane + 2'd1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    logic [63:0] want;
    if (rst) begin
      key_copy = '0;
      left_h   = '0;
      right_h  = '0;
      word_acc = '0;
      lane     = '0;
      msg_open = 1'b0;
      mic_due.delete();
    end else begin
      if (msg.valid && msg.ready) begin
        if (!msg_open) begin
          left_h   = key_copy[31:0];
          right_h  = key_copy[63:32];
          word_acc = '0;
          lane     = '0;
          msg_open = 1'b1;
        end
        if (msg.has_byte) take_byte(msg.data_byte);
        if (msg.last_item) begin
          take_byte(TRAILER_BYTE);
          repeat (ZERO_TAIL) take_byte(8'h00);
          while (lane != 2'd0) take_byte(8'h00);
          mic_due.push_back({right_h, left_h});
          msg_open = 1'b0;
        end
      end
      // A key written at this edge only applies to transactions after it.
      if (cfg_wr_en) key_copy = cfg_wr_data;
      if (mic.valid && mic.ready) begin
        if (mic_due.size() == 0) begin
          report_mismatch("mic_value with no message closed", mic.mic_value, '0);
        end else begin
          want = mic_due.pop_front();
          if (mic.mic_value !== want) report_mismatch("mic_value", mic.mic_value, want);
        end
      end
    end
    pending = mic_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the Michael MIC stream testbench: clock, reset, key writes and message traffic.
module tb_top;

  // Cycles waited after the last MIC before the key may change. Only a
  // closing transaction enters the closing stages, so a transaction that
  // closed no message leaves no block in flight there.
  localparam int DRAIN_SETTLE  = 4;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int MAX_GAP       = 11;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;
  int          fail_count;
  int          pending;
  int          items_sent;
  bit          msg_calm;

  mmic_msg_if msg_ch ();
  mmic_mic_if mic_ch ();

  michael_mic_stream uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .msg         (msg_ch.sink),
    .mic         (mic_ch.source)
  );

  mic_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .msg         (msg_ch),
    .mic         (mic_ch),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The whole run is bounded; a hung handshake or a MIC that never shows up
  // ends here.
  initial begin
    #1_000_000;
    $display("FAIL michael_mic_stream");
    $finish;
  end

  // The MIC receiver draws a stall before every transaction. Now and then it
  // flips into a calm stretch where it takes every MIC at once, so that the
  // block sees both steady flow and backpressure that fills its closing stages.
  initial begin : mic_receiver
    int stall;
    bit calm;
    calm = 1'b0;
    mic_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      stall = calm ? 0 : int'($urandom_range(0, MAX_GAP));
      if (stall != 0) begin
        mic_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      mic_ch.ready <= 1'b1;
      do @(posedge clk); while (!mic_ch.valid);
    end
  end

  // Offers one transaction and returns at the edge that accepted it. Valid is
  // left high, so a following transaction with no gap goes out back to back;
  // a gap or an idle stretch lowers it first.
  task automatic send_item(input logic [7:0] b, input bit hb, input bit li);
    int gap;
    gap = msg_calm ? 0 : int'($urandom_range(0, MAX_GAP));
    if (gap != 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= b;
    msg_ch.has_byte  <= hb;
    msg_ch.last_item <= li;
    do @(posedge clk); while (!msg_ch.ready);
    items_sent++;
  endtask

  // Stops the byte stream and waits until every closed message has delivered
  // its MIC, then lets the pipeline settle. Polling happens on the falling
  // edge so that the checker's count for the rising edge is already final.
  task automatic drain();
    msg_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Key writes only happen with the block idle, right after a drain.
  task automatic load_key(input logic [63:0] k);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One message of nbytes bytes. Transactions without a byte, with random
  // data that the block has to ignore, are sprinkled in. The closing
  // transaction carries the final byte half of the time. With close at 0 the
  // message stays open, so the next key write lands mid-message.
  task automatic send_message(input int nbytes, input bit close);
    int i;
    bit tail_byte;
    tail_byte = close && (nbytes > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < nbytes - tail_byte; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    if (close) send_item(8'($urandom_range(0, 255)), tail_byte, 1'b1);
  endtask

  initial begin : stimulus
    int random_end;
    int n_msgs;
    int len;
    int m;
    bit open_end;
    logic [63:0] k;

    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    msg_ch.valid     <= 1'b0;
    msg_ch.data_byte <= '0;
    msg_ch.has_byte  <= 1'b0;
    msg_ch.last_item <= 1'b0;
    items_sent = 0;
    msg_calm   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. First the empty message under the key left by reset:
    // a closing transaction without a byte on a closed message.
    send_item(8'h00, 1'b0, 1'b1);

    // All-ones key and a single all-ones byte.
    drain();
    load_key(64'hffff_ffff_ffff_ffff);
    send_item(8'hff, 1'b1, 1'b1);

    // Four bytes where the closing transaction carries the fourth one, with an
    // ignored byte in the middle that must not enter the word.
    drain();
    load_key(64'h0123_4567_89ab_cdef);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);

    // A full word, then a closing transaction without a byte.
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0);
    send_item(8'h04, 1'b1, 1'b0);
    send_item(8'h08, 1'b1, 1'b0);
    send_item(8'hc3, 1'b0, 1'b1);

    // An empty message that is opened by a transaction without a byte.
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);

    // The key changes mid-message: the open message keeps the old halves and
    // only the message after it starts from the new all-zero key.
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0);
    drain();
    load_key(64'h0);
    send_item(8'h33, 1'b1, 1'b0);
    send_item(8'h44, 1'b1, 1'b1);
    send_item(8'h55, 1'b1, 1'b1);

    // Random part, in phases. Every phase starts idle with a fresh key, often
    // one of the extremes, then runs a handful of messages of mostly short
    // length with an occasional long one. Some phases end with the message
    // still open so that the next key write falls in the middle of it.
    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      drain();
      case ($urandom_range(0, 5))
        0:       k = 64'h0;
        1:       k = 64'hffff_ffff_ffff_ffff;
        default: k = {$urandom(), $urandom()};
      endcase
      load_key(k);
      n_msgs = int'($urandom_range(1, 6));
      for (m = 0; m < n_msgs; m++) begin
        msg_calm = ($urandom_range(0, 4) == 0);
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 40))
                                          : int'($urandom_range(0, 12));
        open_end = (m == n_msgs - 1) && ($urandom_range(0, 7) == 0);
        send_message(len, !open_end);
      end
    end

    drain();
    if (fail_count == 0) $display("PASS michael_mic_stream");
    else $display("FAIL michael_mic_stream");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mmic_pkg.sv
sv/mmic_if.sv
sv/mmic_round_stage.sv
sv/michael_mic_stream.sv
test/mic_check.sv
test/tb_top.sv
